### sv/tip_heater_pid_controller_defines.svh
// Assertion macros shared by the tip heater PID controller RTL.
`ifndef TIP_HEATER_PID_CONTROLLER_DEFINES_SVH
`define TIP_HEATER_PID_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define THPID_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("thpid assertion failed");
`define THPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("thpid assertion failed");
`else
`define THPID_ASSERT(label, prop)
`define THPID_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/thpid_pkg.sv
// Types and constants shared by the tip heater PID controller modules.
package thpid_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX = 2'd3;

    localparam logic [15:0] RST_GAIN_P     = 16'd15;
    localparam logic [15:0] RST_GAIN_I     = 16'd2;
    localparam logic [15:0] RST_GAIN_D     = 16'd1;
    localparam logic [15:0] RST_OUTPUT_MAX = 16'd6000;

    // Heat state codes.
    localparam logic [1:0] HS_BELOW = 2'd0;
    localparam logic [1:0] HS_ABOVE = 2'd1;
    localparam logic [1:0] HS_BAND  = 2'd2;

    // Thresholds on the exact 17-bit gap (setpoint minus temperature).
    localparam logic signed [16:0] GAP_BAND      = 17'sd18;
    localparam logic signed [16:0] GAP_OVERSHOOT = 17'sd20;
    // Thresholds on the wrapped 16-bit error.
    localparam logic signed [15:0] ERR_INTEG_LIMIT = 16'sd500;
    localparam logic signed [15:0] ERR_DERIV_LIMIT = 16'sd30;

    localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SUM_MIN = -32'sh7FFF_FFFF - 32'sd1;

    // Datapath widths.
    localparam int PP_W  = 33;   // gain_p * error
    localparam int PI_W  = 49;   // gain_i * integral
    localparam int PD_W  = 34;   // gain_d * error difference
    localparam int SUM_W = 50;   // sum of the three terms

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] output_max;
    } t_cfg;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic signed [15:0] err;
        logic [1:0]         heat_state;
        logic               integ;
        logic               ovr;
        logic               use_d;
    } t_cmd;

endpackage

### sv/thpid_in_if.sv
// Input channel: measured tip temperature and setpoint.
interface thpid_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tip_temp;
    logic signed [15:0] target_temp;

    modport source (output valid, tip_temp, target_temp, input ready);
    modport sink (input valid, tip_temp, target_temp, output ready);
endinterface

### sv/thpid_out_if.sv
// Result channel: heater on time and heat state.
interface thpid_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heat_time;
    logic [1:0]  heat_state;

    modport source (output valid, heat_time, heat_state, input ready);
    modport sink (input valid, heat_time, heat_state, output ready);
endinterface

### sv/thpid_front.sv
// Front end: accepts items, forms the error and classifies it.
module thpid_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thpid_in_if.sink      i_item,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output thpid_pkg::t_cmd o_cmd
);
    import thpid_pkg::*;

    logic               r_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic signed [16:0] gap;
    logic               take;

    assign i_item.ready = !r_valid || i_cmd_ready;
    assign take         = i_item.valid && i_item.ready;

    always_comb begin
        gap = 17'($signed(i_item.target_temp)) - 17'($signed(i_item.tip_temp));
        n_cmd.err = gap[15:0];
        if (gap >= GAP_BAND) begin
            n_cmd.heat_state = HS_BELOW;
        end else if (gap < -GAP_BAND) begin
            n_cmd.heat_state = HS_ABOVE;
        end else begin
            n_cmd.heat_state = HS_BAND;
        end
        n_cmd.ovr   = gap < -GAP_OVERSHOOT;
        n_cmd.integ = $signed(gap[15:0]) < ERR_INTEG_LIMIT;
        n_cmd.use_d = $signed(gap[15:0]) > ERR_DERIV_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

### sv/thpid_queue.sv
// Short queue of classified items between the front and the back.
`include "tip_heater_pid_controller_defines.svh"
module thpid_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  thpid_pkg::t_cmd i_push_data,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output thpid_pkg::t_cmd o_pop_data,
    input  logic            i_pop
);
    import thpid_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `THPID_ASSERT(a_count_in_range, r_count <= QCNT_W'(QUEUE_DEPTH))
    `THPID_ASSERT(a_empty_ptrs_meet, (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
endmodule

### sv/thpid_back.sv
// Back end: integral update, the three products, their sum and the output clamp.
`include "tip_heater_pid_controller_defines.svh"
module thpid_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thpid_pkg::t_cfg i_cfg,
    input  logic            i_q_valid,
    input  thpid_pkg::t_cmd i_q_cmd,
    output logic            o_q_pop,
    thpid_out_if.source     o_result
);
    import thpid_pkg::*;

    logic en;

    // Control: one valid bit per stage, all advancing together.
    logic r_va, r_vb, r_vc, r_vd;

    // State carried from item to item.
    logic signed [31:0] r_err_sum;
    logic signed [15:0] r_prev_err;

    // Stage A: operands of the products.
    logic signed [15:0] r_a_err;
    logic signed [31:0] r_a_int;
    logic signed [16:0] r_a_diff;
    logic [1:0]         r_a_state;

    // Stage B: products.
    logic signed [PP_W-1:0] r_b_pp;
    logic signed [PI_W-1:0] r_b_pi;
    logic signed [PD_W-1:0] r_b_pd;
    logic [1:0]             r_b_state;

    // Stage C: sum.
    logic signed [SUM_W-1:0] r_c_sum;
    logic [1:0]              r_c_state;

    // Stage D: clamped result.
    logic [15:0] r_d_time;
    logic [1:0]  r_d_state;

    logic signed [15:0]      err;
    logic signed [32:0]      sum_wide;
    logic signed [31:0]      sum_sat;
    logic signed [31:0]      n_err_sum;
    logic                    use_i;
    logic signed [16:0]      n_a_diff;
    logic signed [PP_W-1:0]  n_b_pp;
    logic signed [PI_W-1:0]  n_b_pi;
    logic signed [PD_W-1:0]  n_b_pd;
    logic signed [SUM_W-1:0] n_c_sum;
    logic [15:0]             n_d_time;

    assign en      = !r_vd || o_result.ready;
    assign o_q_pop = en && i_q_valid;

    always_comb begin
        err      = i_q_cmd.err;
        sum_wide = 33'(r_err_sum) + 33'(err);
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[31:0];
        end
        if (i_q_cmd.ovr) begin
            n_err_sum = '0;
        end else if (i_q_cmd.integ) begin
            n_err_sum = sum_sat;
        end else begin
            n_err_sum = r_err_sum;
        end
        use_i    = i_q_cmd.integ && !i_q_cmd.ovr;
        n_a_diff = i_q_cmd.use_d ? (17'(err) - 17'(r_prev_err)) : '0;
    end

    always_comb begin
        n_b_pp = $signed({1'b0, i_cfg.gain_p}) * r_a_err;
        n_b_pi = $signed({1'b0, i_cfg.gain_i}) * r_a_int;
        n_b_pd = $signed({1'b0, i_cfg.gain_d}) * r_a_diff;
    end

    always_comb begin
        n_c_sum = SUM_W'(r_b_pp) + SUM_W'(r_b_pi) + SUM_W'(r_b_pd);
    end

    always_comb begin
        if (r_c_sum[SUM_W-1]) begin
            n_d_time = '0;
        end else if (r_c_sum > $signed({{(SUM_W-16){1'b0}}, i_cfg.output_max})) begin
            n_d_time = i_cfg.output_max;
        end else begin
            n_d_time = r_c_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va       <= 1'b0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            r_vd       <= 1'b0;
            r_err_sum  <= '0;
            r_prev_err <= '0;
        end else if (en) begin
            r_va <= i_q_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            if (i_q_valid) begin
                r_err_sum  <= n_err_sum;
                r_prev_err <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_err   <= err;
            r_a_int   <= use_i ? n_err_sum : '0;
            r_a_diff  <= n_a_diff;
            r_a_state <= i_q_cmd.heat_state;
            r_b_pp    <= n_b_pp;
            r_b_pi    <= n_b_pi;
            r_b_pd    <= n_b_pd;
            r_b_state <= r_a_state;
            r_c_sum   <= n_c_sum;
            r_c_state <= r_b_state;
            r_d_time  <= n_d_time;
            r_d_state <= r_c_state;
        end
    end

    assign o_result.valid      = r_vd;
    assign o_result.heat_time  = r_d_time;
    assign o_result.heat_state = r_d_state;

    `THPID_ASSERT_NEXT(a_overshoot_clears, o_q_pop && i_q_cmd.ovr, r_err_sum == '0)
    `THPID_ASSERT_NEXT(a_negative_gives_zero, en && r_vc && r_c_sum[SUM_W-1], r_d_time == '0)
endmodule

### sv/tip_heater_pid_controller.sv
// Top level of the tip heater PID controller: configuration registers and the pipeline.
//
// Each item carries a measured tip temperature and a setpoint and yields one result:
// the heater on time, kp*e + ki*I + kd*(e - previous e) clamped to [0, output_max],
// and a heat state code (0 at least 18 below setpoint, 1 over 18 above, 2 otherwise).
// The block takes one item per clock cycle when the result side keeps up. An item
// passes through the front register, the four-entry queue's storage and then four
// back-end stages (integral update, products, sum, clamp) before its result appears.
// The four back-end stages advance together, so a stalled result holds the whole
// back end, and the queue lets the front keep taking items meanwhile until it is
// full. Gains and the clamp are written through the plain write port and must only
// be changed while no item is in flight. No memory needs clearing after reset.
`include "tip_heater_pid_controller_defines.svh"
module tip_heater_pid_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [thpid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                       i_cfg_data,
    thpid_in_if.sink                          i_item,
    thpid_out_if.source                       o_result
);
    import thpid_pkg::*;

    t_cfg r_cfg;

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // Register file; every index of the port maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= RST_GAIN_P;
            r_cfg.gain_i     <= RST_GAIN_I;
            r_cfg.gain_d     <= RST_GAIN_D;
            r_cfg.output_max <= RST_OUTPUT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_P:     r_cfg.gain_p     <= i_cfg_data;
                CFG_GAIN_I:     r_cfg.gain_i     <= i_cfg_data;
                CFG_GAIN_D:     r_cfg.gain_d     <= i_cfg_data;
                CFG_OUTPUT_MAX: r_cfg.output_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    thpid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    thpid_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .i_push_data  (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_cmd),
        .i_pop        (q_pop)
    );

    thpid_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

    // The queue never hands an item to the back unless one is stored.
    `THPID_ASSERT(a_pop_needs_item, q_pop |-> q_valid)
endmodule
